[rtl/ps2_mouse_report_transmitter_unit_assert.svh]
// ----------------------------------------------------------------------------
// ps2 mouse report transmitter assertion macros
// shared concurrent assertion forms for the transmitter rtl
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_REPORT_TRANSMITTER_UNIT_ASSERT_SVH
`define PS2_MOUSE_REPORT_TRANSMITTER_UNIT_ASSERT_SVH

// checked on every rising edge outside reset
`define PS2MRT_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// checked on every rising edge, reset included
`define PS2MRT_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[rtl/ps2mrt_pkg.sv]
// ----------------------------------------------------------------------------
// ps2mrt_pkg
// types and constants shared by the ps2 mouse report transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mrt_pkg;

  localparam logic [15:0] HALF_PERIOD_RESET  = 16'd40;
  localparam logic [19:0] IDLE_TIMEOUT_RESET = 20'd50000;

  // register map, byte address 4*index
  localparam logic REG_HALF_PERIOD  = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  // frame layout: start, 8 data, parity, stop
  localparam logic [3:0] LAST_BIT  = 4'd10;
  localparam logic [3:0] PARITY_BIT = 4'd9;
  localparam logic [1:0] LAST_BYTE = 2'd2;

  // status byte fields
  localparam logic [7:0] SB_ALWAYS_ONE = 8'h08;
  localparam logic [7:0] SB_LEFT       = 8'h01;
  localparam logic [7:0] SB_RIGHT      = 8'h02;
  localparam logic [7:0] SB_MIDDLE     = 8'h04;
  localparam logic [7:0] SB_X_SIGN     = 8'h10;
  localparam logic [7:0] SB_Y_SIGN     = 8'h20;
  localparam logic [7:0] SB_X_OVF      = 8'h40;
  localparam logic [7:0] SB_Y_OVF      = 8'h80;

  localparam logic signed [15:0] DELTA_MAX = 16'sd255;
  localparam logic signed [15:0] DELTA_MIN = -16'sd255;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_SENT     = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_WAIT = 4'b0010,
    MODE_SEND = 4'b0100,
    MODE_HOLD = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [19:0] idle_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic               clock_line;
    logic               data_line;
    logic               left_button;
    logic               right_button;
    logic               middle_button;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } item_t;

  typedef struct packed {
    logic    clock_low;
    logic    data_low;
    logic    busy_res;
    status_t status;
  } res_t;

endpackage

`default_nettype wire

[rtl/ps2_mouse_report_transmitter_unit.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_report_transmitter_unit
// ps2 mouse-side transmitter for standard three byte movement packets
// ----------------------------------------------------------------------------
// Each item is a time tick carrying the sampled clock and data levels, or a
// mouse report. Every item gives exactly one result: the clock and data line
// drives, a busy flag and a status code, all showing the state after that
// item. One item is taken per clock cycle when the result side keeps up; an
// item passes an input register and then the state update into the result
// register. The line timing is counted in ticks only, so a half period of
// the line lasts half_period_ticks ticks.
`default_nettype none

module ps2_mouse_report_transmitter_unit
  import ps2mrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic        in_clock_line,
  input  wire logic        in_data_line,
  input  wire logic        in_left_button,
  input  wire logic        in_right_button,
  input  wire logic        in_middle_button,
  input  wire logic signed [15:0] in_dx,
  input  wire logic signed [15:0] in_dy,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_clock_low,
  output logic             out_data_low,
  output logic             out_busy_res,
  output logic      [2:0]  out_status,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  cfg_t  cfg;
  item_t item_r;
  res_t  res;
  logic  in_valid_r;
  logic  out_valid_r;
  logic  advance;
  logic  step;

  ps2mrt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  // result register moves whenever it is empty or being taken
  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance)  out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.operation     <= in_operation;
      item_r.clock_line    <= in_clock_line;
      item_r.data_line     <= in_data_line;
      item_r.left_button   <= in_left_button;
      item_r.right_button  <= in_right_button;
      item_r.middle_button <= in_middle_button;
      item_r.dx            <= in_dx;
      item_r.dy            <= in_dy;
    end
  end

  ps2mrt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .item_i (item_r),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid     = out_valid_r;
  assign out_clock_low = res.clock_low;
  assign out_data_low  = res.data_low;
  assign out_busy_res  = res.busy_res;
  assign out_status    = res.status;

endmodule

`default_nettype wire

[rtl/ps2mrt_cfg.sv]
// ----------------------------------------------------------------------------
// ps2mrt_cfg
// apb register file holding the line timing settings
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mrt_cfg
  import ps2mrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [15:0] half_period_r;
  logic [19:0] idle_timeout_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r  <= HALF_PERIOD_RESET;
      idle_timeout_r <= IDLE_TIMEOUT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_HALF_PERIOD:  half_period_r  <= pwdata[15:0];
        REG_IDLE_TIMEOUT: idle_timeout_r <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HALF_PERIOD:  prdata = {16'd0, half_period_r};
      REG_IDLE_TIMEOUT: prdata = {12'd0, idle_timeout_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o.half_period_ticks  = half_period_r;
  assign cfg_o.idle_timeout_ticks = idle_timeout_r;

endmodule

`default_nettype wire

[rtl/ps2mrt_core.sv]
// ----------------------------------------------------------------------------
// ps2mrt_core
// packet builder, bus wait, bit timing and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mrt_core
  import ps2mrt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

`include "ps2_mouse_report_transmitter_unit_assert.svh"

  mode_t       mode_r,       mode_nxt;
  logic [7:0]  pkt_r [3];
  logic [7:0]  pkt_nxt [3];
  logic [1:0]  byte_idx_r,   byte_idx_nxt;
  logic [3:0]  bit_idx_r,    bit_idx_nxt;
  logic [1:0]  sub_r,        sub_nxt;
  logic [15:0] tick_r,       tick_nxt;
  logic [19:0] wait_r,       wait_nxt;
  logic        parity_r,     parity_nxt;
  logic        clk_drv_r,    clk_drv_nxt;
  logic        dat_drv_r,    dat_drv_nxt;
  status_t     status_nxt;
  res_t        res_r;

  logic [16:0] tick_inc;
  logic [15:0] hp_limit;
  logic        half_done;
  logic [7:0]  cur_byte;
  logic        cur_bit;
  logic [3:0]  bit_next;
  logic [9:0]  x_cl;
  logic [9:0]  y_cl;
  logic [7:0]  sbyte;

  // returns {overflow, sign, byte}
  function automatic logic [9:0] clamp_delta(input logic signed [15:0] v);
    logic       ovf;
    logic [7:0] b;
    ovf = (v > DELTA_MAX) || (v < DELTA_MIN);
    if (v > DELTA_MAX)      b = DELTA_MAX[7:0];
    else if (v < DELTA_MIN) b = DELTA_MIN[7:0];
    else                    b = v[7:0];
    return {ovf, v[15], b};
  endfunction

  assign x_cl = clamp_delta(item_i.dx);
  assign y_cl = clamp_delta(item_i.dy);

  always_comb begin
    sbyte = SB_ALWAYS_ONE;
    if (item_i.left_button)   sbyte = sbyte | SB_LEFT;
    if (item_i.right_button)  sbyte = sbyte | SB_RIGHT;
    if (item_i.middle_button) sbyte = sbyte | SB_MIDDLE;
    if (x_cl[8])              sbyte = sbyte | SB_X_SIGN;
    if (y_cl[8])              sbyte = sbyte | SB_Y_SIGN;
    if (x_cl[9])              sbyte = sbyte | SB_X_OVF;
    if (y_cl[9])              sbyte = sbyte | SB_Y_OVF;
  end

  // a zero half period counts as one tick
  assign hp_limit  = (cfg_i.half_period_ticks == 16'd0) ? 16'd1 : cfg_i.half_period_ticks;
  assign tick_inc  = {1'b0, tick_r} + 17'd1;
  assign half_done = tick_inc >= {1'b0, hp_limit};

  always_comb begin
    case (byte_idx_r)
      2'd0:    cur_byte = pkt_r[0];
      2'd1:    cur_byte = pkt_r[1];
      2'd2:    cur_byte = pkt_r[2];
      default: cur_byte = pkt_r[0];
    endcase
  end

  // data bit b sits at byte bit b-1, which is the current bit index
  assign cur_bit  = cur_byte[bit_idx_r[2:0]];
  assign bit_next = bit_idx_r + 4'd1;

  always_comb begin
    mode_nxt     = mode_r;
    pkt_nxt      = pkt_r;
    byte_idx_nxt = byte_idx_r;
    bit_idx_nxt  = bit_idx_r;
    sub_nxt      = sub_r;
    tick_nxt     = tick_r;
    wait_nxt     = wait_r;
    parity_nxt   = parity_r;
    clk_drv_nxt  = clk_drv_r;
    dat_drv_nxt  = dat_drv_r;
    status_nxt   = ST_NONE;

    if (item_i.operation) begin
      if (mode_r != MODE_IDLE) begin
        status_nxt = ST_REJECTED;
      end else begin
        pkt_nxt[0]   = sbyte;
        pkt_nxt[1]   = x_cl[7:0];
        pkt_nxt[2]   = y_cl[7:0];
        mode_nxt     = MODE_WAIT;
        clk_drv_nxt  = 1'b0;
        dat_drv_nxt  = 1'b0;
        byte_idx_nxt = 2'd0;
        bit_idx_nxt  = 4'd0;
        sub_nxt      = 2'd0;
        tick_nxt     = 16'd0;
        wait_nxt     = 20'd0;
        status_nxt   = ST_ACCEPTED;
      end
    end else begin
      case (mode_r)
        MODE_WAIT: begin
          if (item_i.clock_line && item_i.data_line) begin
            // bus free: start bit goes out at once
            parity_nxt  = 1'b1;
            bit_idx_nxt = 4'd0;
            sub_nxt     = 2'd0;
            tick_nxt    = 16'd0;
            clk_drv_nxt = 1'b0;
            dat_drv_nxt = 1'b1;
            mode_nxt    = MODE_SEND;
          end else if (wait_r >= cfg_i.idle_timeout_ticks) begin
            mode_nxt     = MODE_IDLE;
            clk_drv_nxt  = 1'b0;
            dat_drv_nxt  = 1'b0;
            byte_idx_nxt = 2'd0;
            bit_idx_nxt  = 4'd0;
            sub_nxt      = 2'd0;
            tick_nxt     = 16'd0;
            wait_nxt     = 20'd0;
            status_nxt   = ST_TIMEOUT;
          end else begin
            wait_nxt = wait_r + 20'd1;
          end
        end
        MODE_SEND: begin
          if (!half_done) begin
            tick_nxt = tick_inc[15:0];
          end else begin
            tick_nxt = 16'd0;
            case (sub_r)
              2'd0: begin
                sub_nxt     = 2'd1;
                clk_drv_nxt = 1'b1;
              end
              2'd1: begin
                sub_nxt     = 2'd2;
                clk_drv_nxt = 1'b0;
              end
              default: begin
                sub_nxt = 2'd0;
                if (bit_idx_r >= LAST_BIT) begin
                  dat_drv_nxt = 1'b0;
                  mode_nxt    = MODE_HOLD;
                end else begin
                  bit_idx_nxt = bit_next;
                  if (bit_next < PARITY_BIT) begin
                    parity_nxt  = parity_r ^ cur_bit;
                    dat_drv_nxt = !cur_bit;
                  end else if (bit_next == PARITY_BIT) begin
                    dat_drv_nxt = !parity_r;
                  end else begin
                    // stop bit released high
                    dat_drv_nxt = 1'b0;
                  end
                end
              end
            endcase
          end
        end
        MODE_HOLD: begin
          if (!half_done) begin
            tick_nxt = tick_inc[15:0];
          end else begin
            tick_nxt = 16'd0;
            if (sub_r == 2'd0) begin
              sub_nxt = 2'd1;
            end else if (byte_idx_r >= LAST_BYTE) begin
              mode_nxt     = MODE_IDLE;
              clk_drv_nxt  = 1'b0;
              dat_drv_nxt  = 1'b0;
              byte_idx_nxt = 2'd0;
              bit_idx_nxt  = 4'd0;
              sub_nxt      = 2'd0;
              wait_nxt     = 20'd0;
              status_nxt   = ST_SENT;
            end else begin
              byte_idx_nxt = byte_idx_r + 2'd1;
              sub_nxt      = 2'd0;
              wait_nxt     = 20'd0;
              mode_nxt     = MODE_WAIT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      byte_idx_r <= 2'd0;
      bit_idx_r  <= 4'd0;
      sub_r      <= 2'd0;
      tick_r     <= 16'd0;
      wait_r     <= 20'd0;
      parity_r   <= 1'b1;
      clk_drv_r  <= 1'b0;
      dat_drv_r  <= 1'b0;
    end else if (step_i) begin
      mode_r     <= mode_nxt;
      byte_idx_r <= byte_idx_nxt;
      bit_idx_r  <= bit_idx_nxt;
      sub_r      <= sub_nxt;
      tick_r     <= tick_nxt;
      wait_r     <= wait_nxt;
      parity_r   <= parity_nxt;
      clk_drv_r  <= clk_drv_nxt;
      dat_drv_r  <= dat_drv_nxt;
    end
  end

  // packet bytes and result are payload, only read once written
  always_ff @(posedge clk) begin
    if (step_i) begin
      pkt_r[0]        <= pkt_nxt[0];
      pkt_r[1]        <= pkt_nxt[1];
      pkt_r[2]        <= pkt_nxt[2];
      res_r.clock_low <= clk_drv_nxt;
      res_r.data_low  <= dat_drv_nxt;
      res_r.busy_res  <= (mode_nxt != MODE_IDLE);
      res_r.status    <= status_nxt;
    end
  end

  assign res_o = res_r;

  `PS2MRT_ASSERT(a_idle_released, clk, rst_n,
    (mode_r == MODE_IDLE) |-> (!clk_drv_r && !dat_drv_r), "lines driven while idle")
  `PS2MRT_ASSERT(a_clock_only_in_send, clk, rst_n,
    clk_drv_r |-> (mode_r == MODE_SEND), "clock driven outside a byte")
  `PS2MRT_ASSERT(a_indices_in_range, clk, rst_n,
    (bit_idx_r <= LAST_BIT) && (byte_idx_r <= LAST_BYTE), "frame index out of range")
  `PS2MRT_ASSERT(a_end_status_goes_idle, clk, rst_n,
    (step_i && (status_nxt == ST_SENT || status_nxt == ST_TIMEOUT)) |=> (mode_r == MODE_IDLE),
    "packet end did not return to idle")
  `PS2MRT_ASSERT(a_accept_goes_wait, clk, rst_n,
    (step_i && status_nxt == ST_ACCEPTED) |=> (mode_r == MODE_WAIT && res_r.busy_res),
    "accepted report did not start bus wait")

endmodule

`default_nettype wire

[test/tb_ps2_mouse_report_transmitter_unit.sv]
// ----------------------------------------------------------------------------
// tb_ps2_mouse_report_transmitter_unit
// checks the ps2 mouse report transmitter item by item against its own model
// ----------------------------------------------------------------------------
// Reports and line-sample ticks go in over a valid/ready channel. Each
// accepted item is run through a behavioural model of the transmitter that
// works out the line drives, busy flag and status, and every result is
// compared field by field in order. A short directed table covers reset
// values, delta clamping edges, busy rejection, bus time-outs and the zero
// register values. Random traffic then runs full packets under several
// register settings, one of them with no idling on either side.
module tb_ps2_mouse_report_transmitter_unit
  import ps2mrt_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int GAP_PERCENT    = 37;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_FINISH,
    STEP_CONFIG
  } step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    item_t       it;
    logic        typed;
    res_t        want;
    logic        reg_sel;
    logic [31:0] reg_val;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_operation = 1'b0;
  logic               in_clock_line = 1'b0;
  logic               in_data_line = 1'b0;
  logic               in_left_button = 1'b0;
  logic               in_right_button = 1'b0;
  logic               in_middle_button = 1'b0;
  logic signed [15:0] in_dx = '0;
  logic signed [15:0] in_dy = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_clock_low;
  logic               out_data_low;
  logic               out_busy_res;
  logic [2:0]         out_status;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  ps2_mouse_report_transmitter_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_clock_line    (in_clock_line),
    .in_data_line     (in_data_line),
    .in_left_button   (in_left_button),
    .in_right_button  (in_right_button),
    .in_middle_button (in_middle_button),
    .in_dx            (in_dx),
    .in_dy            (in_dy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_clock_low    (out_clock_low),
    .out_data_low     (out_data_low),
    .out_busy_res     (out_busy_res),
    .out_status       (out_status),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  mode_t       tx_mode;
  logic [7:0]  pkt [3];
  logic [1:0]  byte_sel;
  logic [3:0]  bit_sel;
  logic [1:0]  half_sel;
  logic [15:0] tick_cnt;
  logic [19:0] wait_cnt;
  logic        odd_par;
  logic        drv_clock;
  logic        drv_data;
  logic [15:0] cur_half;
  logic [19:0] cur_timeout;

  res_t expected_line_states[$];
  bit   no_gaps = 1'b0;
  int   mismatches = 0;
  int   n_items = 0;
  int   n_sent = 0;
  int   n_timeouts = 0;
  int   n_rejected = 0;
  int   n_reg_writes = 0;
  int   idle_cycles = 0;

  function automatic logic [7:0] clamp_delta(input logic signed [15:0] d,
                                             output logic ovf, output logic neg);
    int v;
    v = d;
    ovf = (v < -255) || (v > 255);
    if (v < -255) v = -255;
    if (v > 255) v = 255;
    neg = (v < 0);
    return v[7:0];
  endfunction

  // line level of frame bit b, folding data bits into the parity
  function automatic logic frame_level(input logic [3:0] b);
    logic v;
    if (b == 4'd0) return 1'b0;
    if (b <= 4'd8) begin
      v = pkt[byte_sel][b - 4'd1];
      odd_par = odd_par ^ v;
      return v;
    end
    if (b == PARITY_BIT) return odd_par;
    return 1'b1;
  endfunction

  function automatic void line_idle();
    tx_mode   = MODE_IDLE;
    drv_clock = 1'b0;
    drv_data  = 1'b0;
    byte_sel  = '0;
    bit_sel   = '0;
    half_sel  = '0;
    tick_cnt  = '0;
    wait_cnt  = '0;
  endfunction

  function automatic void begin_byte();
    odd_par   = 1'b1;
    bit_sel   = '0;
    half_sel  = '0;
    tick_cnt  = '0;
    drv_clock = 1'b0;
    drv_data  = !frame_level(4'd0);
    tx_mode   = MODE_SEND;
  endfunction

  function automatic logic half_done();
    logic [15:0] lim;
    lim = (cur_half == 16'd0) ? 16'd1 : cur_half;
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t ps2_line_step(input item_t it);
    res_t       r;
    logic       xo, xn, yo, yn;
    logic [7:0] xb, yb, sb;
    status_t    st;
    st = ST_NONE;
    if (it.operation) begin
      if (tx_mode != MODE_IDLE) begin
        st = ST_REJECTED;
      end else begin
        xb = clamp_delta(it.dx, xo, xn);
        yb = clamp_delta(it.dy, yo, yn);
        sb = SB_ALWAYS_ONE;
        if (it.left_button) sb = sb | SB_LEFT;
        if (it.right_button) sb = sb | SB_RIGHT;
        if (it.middle_button) sb = sb | SB_MIDDLE;
        if (xn) sb = sb | SB_X_SIGN;
        if (yn) sb = sb | SB_Y_SIGN;
        if (xo) sb = sb | SB_X_OVF;
        if (yo) sb = sb | SB_Y_OVF;
        pkt[0] = sb;
        pkt[1] = xb;
        pkt[2] = yb;
        line_idle();
        tx_mode = MODE_WAIT;
        st = ST_ACCEPTED;
      end
    end else begin
      case (tx_mode)
        MODE_WAIT: begin
          if (it.clock_line && it.data_line) begin
            begin_byte();
          end else if (wait_cnt >= cur_timeout) begin
            line_idle();
            st = ST_TIMEOUT;
          end else begin
            wait_cnt = wait_cnt + 20'd1;
          end
        end
        MODE_SEND: begin
          if (half_done()) begin
            if (half_sel == 2'd0) begin
              half_sel  = 2'd1;
              drv_clock = 1'b1;
            end else if (half_sel == 2'd1) begin
              half_sel  = 2'd2;
              drv_clock = 1'b0;
            end else if (bit_sel >= LAST_BIT) begin
              drv_data = 1'b0;
              half_sel = 2'd0;
              tx_mode  = MODE_HOLD;
            end else begin
              half_sel = 2'd0;
              bit_sel  = bit_sel + 4'd1;
              drv_data = !frame_level(bit_sel);
            end
          end
        end
        MODE_HOLD: begin
          if (half_done()) begin
            if (half_sel == 2'd0) begin
              half_sel = 2'd1;
            end else if (byte_sel >= LAST_BYTE) begin
              line_idle();
              st = ST_SENT;
            end else begin
              byte_sel = byte_sel + 2'd1;
              half_sel = 2'd0;
              wait_cnt = '0;
              tx_mode  = MODE_WAIT;
            end
          end
        end
        default: ;
      endcase
    end
    r.clock_low = drv_clock;
    r.data_low  = drv_data;
    r.busy_res  = (tx_mode != MODE_IDLE);
    r.status    = st;
    return r;
  endfunction

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_line_states.size() == 0) begin
        $display("%0t: result expected none got clock_low %0b data_low %0b busy %0b status %0d",
                 $time, out_clock_low, out_data_low, out_busy_res, out_status);
        mismatches++;
      end else begin
        want = expected_line_states.pop_front();
        report_field("clock_low", 32'(want.clock_low), 32'(out_clock_low));
        report_field("data_low", 32'(want.data_low), 32'(out_data_low));
        report_field("busy_res", 32'(want.busy_res), 32'(out_busy_res));
        report_field("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && (no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT));
  end

  // counts cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input item_t it, input logic typed, input res_t want);
    res_t got;
    while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= it.operation;
    in_clock_line    <= it.clock_line;
    in_data_line     <= it.data_line;
    in_left_button   <= it.left_button;
    in_right_button  <= it.right_button;
    in_middle_button <= it.middle_button;
    in_dx            <= it.dx;
    in_dy            <= it.dy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = ps2_line_step(it);
    expected_line_states.push_back(typed ? want : got);
    n_items++;
    case (got.status)
      ST_SENT:     n_sent++;
      ST_TIMEOUT:  n_timeouts++;
      ST_REJECTED: n_rejected++;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_line_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] val);
    logic [31:0] mask;
    mask = (sel == REG_HALF_PERIOD) ? 32'h0000_FFFF : 32'h000F_FFFF;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (sel == REG_HALF_PERIOD) cur_half = val[15:0];
    else cur_timeout = val[19:0];
    n_reg_writes++;
    // read back over the same port
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    report_field(sel == REG_HALF_PERIOD ? "half_period_ticks readback" :
                 "idle_timeout_ticks readback", val & mask, cfg_prdata & mask);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic signed [15:0] random_delta();
    int v;
    case ($urandom_range(0, 2))
      0: v = $urandom_range(0, 600) - 300;
      1: begin
        case ($urandom_range(0, 7))
          0: v = -32768;
          1: v = 32767;
          2: v = -256;
          3: v = -255;
          4: v = 255;
          5: v = 256;
          6: v = 0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  // mostly well-formed: reports when idle, free bus while waiting
  function automatic item_t next_traffic_item();
    item_t it;
    int    pick;
    it.operation     = 1'b0;
    it.clock_line    = 1'($urandom);
    it.data_line     = 1'($urandom);
    it.left_button   = 1'($urandom);
    it.right_button  = 1'($urandom);
    it.middle_button = 1'($urandom);
    it.dx            = random_delta();
    it.dy            = random_delta();
    pick = $urandom_range(0, 99);
    if (tx_mode == MODE_IDLE) begin
      it.operation = (pick < 40);
    end else if (pick < 2) begin
      it.operation = 1'b1;
    end else if (tx_mode == MODE_WAIT && pick < 75) begin
      it.clock_line = 1'b1;
      it.data_line  = 1'b1;
    end
    return it;
  endfunction

  // ticks with a free bus until the packet in flight is done
  task automatic finish_packet();
    item_t it;
    while (tx_mode != MODE_IDLE) begin
      it = next_traffic_item();
      it.operation  = 1'b0;
      it.clock_line = 1'b1;
      it.data_line  = 1'b1;
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [15:0] hp, input logic [19:0] to,
                           input bit quiet, input int count);
    finish_packet();
    settle();
    write_reg(REG_HALF_PERIOD, {16'd0, hp});
    write_reg(REG_IDLE_TIMEOUT, {12'd0, to});
    no_gaps = quiet;
    repeat (count) send_item(next_traffic_item(), 1'b0, '0);
    no_gaps = 1'b0;
  endtask

  function automatic plan_row_t tick_row(input logic cl, input logic dl);
    plan_row_t r;
    r = '0;
    r.kind = STEP_ITEM;
    r.it.clock_line = cl;
    r.it.data_line  = dl;
    return r;
  endfunction

  function automatic plan_row_t report_row(input logic [2:0] btn,
                                           input logic signed [15:0] dx,
                                           input logic signed [15:0] dy);
    plan_row_t r;
    r = '0;
    r.kind = STEP_ITEM;
    r.it.operation     = 1'b1;
    r.it.clock_line    = btn[0];
    r.it.data_line     = btn[1];
    r.it.left_button   = btn[0];
    r.it.right_button  = btn[1];
    r.it.middle_button = btn[2];
    r.it.dx = dx;
    r.it.dy = dy;
    return r;
  endfunction

  function automatic plan_row_t config_row(input logic sel, input logic [31:0] val);
    plan_row_t r;
    r = '0;
    r.kind    = STEP_CONFIG;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  function automatic plan_row_t expecting(input plan_row_t row, input logic cl,
                                          input logic dl, input logic busy,
                                          input status_t st);
    plan_row_t r;
    r = row;
    r.typed          = 1'b1;
    r.want.clock_low = cl;
    r.want.data_low  = dl;
    r.want.busy_res  = busy;
    r.want.status    = st;
    return r;
  endfunction

  initial begin
    plan_row_t plan[$];
    plan_row_t fin;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    line_idle();
    pkt[0] = '0;
    pkt[1] = '0;
    pkt[2] = '0;
    odd_par     = 1'b1;
    cur_half    = HALF_PERIOD_RESET;
    cur_timeout = IDLE_TIMEOUT_RESET;

    fin = '0;
    fin.kind = STEP_FINISH;

    // short half period keeps the first packet brief
    plan.push_back(config_row(REG_HALF_PERIOD, 32'd1));
    // idle tick, clamped extremes, busy rejection, bus wait
    plan.push_back(expecting(tick_row(1'b0, 1'b0), 1'b0, 1'b0, 1'b0, ST_NONE));
    plan.push_back(expecting(report_row(3'b111, 16'sh8000, 16'sh7FFF),
                             1'b0, 1'b0, 1'b1, ST_ACCEPTED));
    plan.push_back(expecting(report_row(3'b000, 16'sd0, 16'sd0),
                             1'b0, 1'b0, 1'b1, ST_REJECTED));
    plan.push_back(expecting(tick_row(1'b0, 1'b1), 1'b0, 1'b0, 1'b1, ST_NONE));
    plan.push_back(expecting(tick_row(1'b1, 1'b1), 1'b0, 1'b1, 1'b1, ST_NONE));
    // host pulls data low mid-byte, not looked at
    plan.push_back(tick_row(1'b1, 1'b0));
    plan.push_back(fin);
    // zero half period and zero time-out
    plan.push_back(config_row(REG_HALF_PERIOD, 32'd0));
    plan.push_back(config_row(REG_IDLE_TIMEOUT, 32'd0));
    plan.push_back(expecting(report_row(3'b001, 16'sd255, -16'sd255),
                             1'b0, 1'b0, 1'b1, ST_ACCEPTED));
    plan.push_back(expecting(tick_row(1'b1, 1'b0), 1'b0, 1'b0, 1'b0, ST_TIMEOUT));
    plan.push_back(expecting(report_row(3'b010, 16'sd256, -16'sd256),
                             1'b0, 1'b0, 1'b1, ST_ACCEPTED));
    plan.push_back(expecting(tick_row(1'b0, 1'b0), 1'b0, 1'b0, 1'b0, ST_TIMEOUT));
    plan.push_back(expecting(report_row(3'b100, 16'sh7FFF, 16'sh8000),
                             1'b0, 1'b0, 1'b1, ST_ACCEPTED));
    plan.push_back(expecting(tick_row(1'b1, 1'b1), 1'b0, 1'b1, 1'b1, ST_NONE));
    plan.push_back(tick_row(1'b1, 1'b1));
    plan.push_back(fin);
    // time-out after a short busy bus
    plan.push_back(config_row(REG_IDLE_TIMEOUT, 32'd2));
    plan.push_back(report_row(3'b000, -16'sd1, 16'sd1));
    plan.push_back(tick_row(1'b0, 1'b1));
    plan.push_back(tick_row(1'b1, 1'b0));
    plan.push_back(expecting(tick_row(1'b0, 1'b0), 1'b0, 1'b0, 1'b0, ST_TIMEOUT));

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_ITEM: send_item(plan[i].it, plan[i].typed, plan[i].want);
        STEP_FINISH: finish_packet();
        default: begin
          settle();
          write_reg(plan[i].reg_sel, plan[i].reg_val);
        end
      endcase
    end

    run_phase(16'd1, 20'hFFFFF, 1'b0, 280);
    run_phase(16'd2, 20'd6, 1'b1, 280);
    run_phase(16'd1, 20'd0, 1'b0, 280);
    run_phase(16'd3, 20'd20, 1'b0, 280);
    run_phase(16'($urandom_range(1, 4)), 20'($urandom_range(0, 40)), 1'b0, 280);

    in_valid <= 1'b0;
    while (expected_line_states.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d items over %0d register writes", n_items, n_reg_writes);
    $display("%0d packets sent, %0d bus time-outs, %0d busy rejections",
             n_sent, n_timeouts, n_rejected);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ps2mrt_pkg.sv
rtl/ps2mrt_cfg.sv
rtl/ps2mrt_core.sv
rtl/ps2_mouse_report_transmitter_unit.sv
test/tb_ps2_mouse_report_transmitter_unit.sv
